### rtl/core/date_time_text_parser_macros.svh
// assertion macros for the date/time text parser
`ifndef DATE_TIME_TEXT_PARSER_MACROS_SVH
`define DATE_TIME_TEXT_PARSER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define DTP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define DTP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DTP_ASSERT_SAME(lbl, ante, cons, msg)
`define DTP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### rtl/core/dtp_pkg.sv
package dtp_pkg;

  localparam logic [4:0] TEXT_LEN = 5'd17;
  localparam logic [4:0] POS_SAT  = 5'd18;

  localparam logic [4:0] POS_DAY   = 5'd0;
  localparam logic [4:0] POS_MONTH = 5'd3;
  localparam logic [4:0] POS_YEAR  = 5'd6;
  localparam logic [4:0] POS_HOUR  = 5'd9;
  localparam logic [4:0] POS_MIN   = 5'd12;
  localparam logic [4:0] POS_SEC   = 5'd15;

  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [6:0] DAY_MAX    = 7'd31;
  localparam logic [6:0] MONTH_MAX  = 7'd12;
  localparam logic [6:0] HOUR_MAX   = 7'd23;
  localparam logic [6:0] MINSEC_MAX = 7'd59;

  typedef struct packed {
    logic [6:0] day;
    logic [6:0] month;
    logic [6:0] year;
    logic [6:0] hour;
    logic [6:0] minute;
    logic [6:0] second;
  } dtp_fields_t;

  typedef struct packed {
    dtp_fields_t fields;
    logic [4:0]  pos;
    logic        err;
  } dtp_parse_t;

  typedef struct packed {
    logic       valid_res;
    logic [4:0] day_value;
    logic [3:0] month_value;
    logic [6:0] year_value;
    logic [4:0] hour_value;
    logic [5:0] minute_value;
    logic [5:0] second_value;
  } dtp_result_t;

  function automatic logic [6:0] month_days(input logic [6:0] month);
    logic [6:0] days;
    case (month)
      7'd2:                       days = 7'd28;
      7'd4, 7'd6, 7'd9, 7'd11:    days = 7'd30;
      default:                    days = 7'd31;
    endcase
    return days;
  endfunction

  function automatic logic [6:0] push_digit(input logic [6:0] acc, input logic [3:0] d);
    return 7'({acc, 3'b000} + {acc, 1'b0} + {3'b000, d});
  endfunction

endpackage

### rtl/core/dtp_in_if.sv
interface dtp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       is_last;

  modport source (output valid, output text_byte, output is_last, input ready);
  modport sink   (input valid, input text_byte, input is_last, output ready);
endinterface

### rtl/core/dtp_out_if.sv
interface dtp_out_if;
  logic       valid;
  logic       ready;
  logic       valid_res;
  logic [4:0] day_value;
  logic [3:0] month_value;
  logic [6:0] year_value;
  logic [4:0] hour_value;
  logic [5:0] minute_value;
  logic [5:0] second_value;

  modport source (output valid, output valid_res, output day_value, output month_value,
                  output year_value, output hour_value, output minute_value,
                  output second_value, input ready);
  modport sink   (input valid, input valid_res, input day_value, input month_value,
                  input year_value, input hour_value, input minute_value,
                  input second_value, output ready);
endinterface

### rtl/core/dtp_byte_parser.sv
module dtp_byte_parser
  import dtp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic [7:0] text_byte,
  input  logic       is_last,
  output dtp_parse_t parse_nxt,
  output logic [4:0] pos
);

  dtp_parse_t state_r;
  dtp_parse_t state_nxt;
  logic       is_digit;
  logic [3:0] digit;

  assign is_digit = (text_byte >= CHAR_ZERO) && (text_byte <= CHAR_NINE);
  assign digit    = 4'(text_byte - CHAR_ZERO);

  always_comb begin
    state_nxt = state_r;
    if (state_r.pos < POS_SAT) begin
      state_nxt.pos = state_r.pos + 5'd1;
    end
    case (state_r.pos)
      POS_MONTH - 5'd1, POS_YEAR - 5'd1: begin
        if (text_byte != CHAR_SLASH) state_nxt.err = 1'b1;
      end
      POS_HOUR - 5'd1: begin
        if (text_byte != CHAR_SPACE) state_nxt.err = 1'b1;
      end
      POS_MIN - 5'd1, POS_SEC - 5'd1: begin
        if (text_byte != CHAR_COLON) state_nxt.err = 1'b1;
      end
      POS_DAY, POS_DAY + 5'd1: begin
        if (!is_digit) state_nxt.err = 1'b1;
        else state_nxt.fields.day = push_digit(state_r.fields.day, digit);
      end
      POS_MONTH, POS_MONTH + 5'd1: begin
        if (!is_digit) state_nxt.err = 1'b1;
        else state_nxt.fields.month = push_digit(state_r.fields.month, digit);
      end
      POS_YEAR, POS_YEAR + 5'd1: begin
        if (!is_digit) state_nxt.err = 1'b1;
        else state_nxt.fields.year = push_digit(state_r.fields.year, digit);
      end
      POS_HOUR, POS_HOUR + 5'd1: begin
        if (!is_digit) state_nxt.err = 1'b1;
        else state_nxt.fields.hour = push_digit(state_r.fields.hour, digit);
      end
      POS_MIN, POS_MIN + 5'd1: begin
        if (!is_digit) state_nxt.err = 1'b1;
        else state_nxt.fields.minute = push_digit(state_r.fields.minute, digit);
      end
      POS_SEC, POS_SEC + 5'd1: begin
        if (!is_digit) state_nxt.err = 1'b1;
        else state_nxt.fields.second = push_digit(state_r.fields.second, digit);
      end
      default: begin
        state_nxt.err = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (en) begin
      if (is_last) state_r <= '0;
      else state_r <= state_nxt;
    end
  end

  assign parse_nxt = state_nxt;
  assign pos       = state_r.pos;

endmodule

### rtl/core/dtp_range_check.sv
module dtp_range_check
  import dtp_pkg::*;
(
  input  dtp_parse_t  parse,
  output dtp_result_t result
);

  dtp_fields_t f;
  logic        ok;

  assign f = parse.fields;

  always_comb begin
    ok = (parse.pos == TEXT_LEN) && !parse.err
         && (f.day != 7'd0) && (f.day <= DAY_MAX)
         && (f.month != 7'd0) && (f.month <= MONTH_MAX)
         && (f.hour <= HOUR_MAX) && (f.minute <= MINSEC_MAX) && (f.second <= MINSEC_MAX)
         && (f.day <= month_days(f.month));
    result = '0;
    if (ok) begin
      result.valid_res    = 1'b1;
      result.day_value    = f.day[4:0];
      result.month_value  = f.month[3:0];
      result.year_value   = f.year;
      result.hour_value   = f.hour[4:0];
      result.minute_value = f.minute[5:0];
      result.second_value = f.second[5:0];
    end
  end

endmodule

### rtl/core/date_time_text_parser.sv
// a result is registered in the output register when its last byte leaves the input register
// throughput: one byte per cycle, set by the combinational digit accumulate and range check
// the input register keeps taking non-last bytes while a result waits on the output register, but holds a last byte
// reset: synchronous active-low rst_n clears both valid flags and the parse state
`include "date_time_text_parser_macros.svh"
module date_time_text_parser
  import dtp_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  dtp_in_if.sink    in_ch,
  dtp_out_if.source out_ch
);

  logic        in_valid_r;
  logic        in_valid_nxt;
  logic [7:0]  text_r;
  logic        last_r;
  logic        out_valid_r;
  logic        out_valid_nxt;
  dtp_result_t result_r;
  dtp_result_t result_nxt;
  dtp_parse_t  parse_nxt;
  logic [4:0]  pos;
  logic        take;
  logic        in_fire;

  // non-last bytes never wait on the output side
  assign take    = in_valid_r && (!last_r || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || take;
  assign in_fire = in_ch.valid && in_ch.ready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_fire) in_valid_nxt = 1'b1;
    else if (take) in_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (take && last_r) out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      text_r <= in_ch.text_byte;
      last_r <= in_ch.is_last;
    end
    if (take && last_r) result_r <= result_nxt;
  end

  dtp_byte_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (take),
    .text_byte (text_r),
    .is_last   (last_r),
    .parse_nxt (parse_nxt),
    .pos       (pos)
  );

  dtp_range_check u_check (
    .parse  (parse_nxt),
    .result (result_nxt)
  );

  assign out_ch.valid        = out_valid_r;
  assign out_ch.valid_res    = result_r.valid_res;
  assign out_ch.day_value    = result_r.day_value;
  assign out_ch.month_value  = result_r.month_value;
  assign out_ch.year_value   = result_r.year_value;
  assign out_ch.hour_value   = result_r.hour_value;
  assign out_ch.minute_value = result_r.minute_value;
  assign out_ch.second_value = result_r.second_value;

  `DTP_ASSERT_NEXT(a_pos_cleared, take && last_r, pos == 5'd0, "position not cleared")
  `DTP_ASSERT_NEXT(a_in_held, in_valid_r && !take, in_valid_r, "held byte dropped")
  `DTP_ASSERT_SAME(a_zero_invalid, out_valid_r && !result_r.valid_res, result_r == '0, "bad fields")
  `DTP_ASSERT_SAME(a_date_range, out_valid_r && result_r.valid_res, result_r.day_value != 5'd0 && result_r.month_value != 4'd0, "zero date")

endmodule
